/* rtl/core/stwq_pkg.sv */
package stwq_pkg;

   localparam int unsigned CmdBits    = 2;
   localparam int unsigned IndexBits  = 4;
   localparam int unsigned ValueBits  = 16;
   localparam int unsigned CallerBits = 16;
   localparam int unsigned StatusBits = 3;
   localparam int unsigned SlotBits   = 4;
   localparam int unsigned WakeBits   = 16;

   typedef enum logic [CmdBits-1:0] {
      CMD_INIT    = 2'd0,
      CMD_UP      = 2'd1,
      CMD_DOWN    = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [StatusBits-1:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_WAITERS   = 3'd2,
      ST_SUSPENDED = 3'd3,
      ST_NO_SPACE  = 3'd4
   } status_type;

   localparam logic [ValueBits-1:0] CountMax = '1;

   typedef struct packed {
      logic [CmdBits-1:0]    cmd;
      logic [IndexBits-1:0]  slot_index;
      logic [ValueBits-1:0]  init_value;
      logic [CallerBits-1:0] caller;
   } req_type;

   typedef struct packed {
      logic [StatusBits-1:0] status;
      logic [SlotBits-1:0]   slot;
      logic                  wake_valid;
      logic [WakeBits-1:0]   wake_endpoint;
   } rsp_type;

endpackage

/* rtl/core/stwq_if.sv */
interface stwq_req_if;
   logic              valid;
   logic              ready;
   stwq_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stwq_rsp_if;
   logic              valid;
   logic              ready;
   stwq_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/semaphore_table_with_wait_queues.sv */
// Semaphore table with per-slot FIFO wait queues. One request is processed at
// a time: the count and queue pointers of the addressed slot are read from a
// synchronous table memory, modified, and written back; the result is then
// held until rsp ready. Waiter ids live in a second memory (NUM_SEMS*WAIT_DEPTH
// words) read through a registered port at the queue head just fetched. After
// an init that reuses a released slot, the next-lowest released slot is found by
// a scan of the busy bits, one slot a cycle, before the result is offered.
module semaphore_table_with_wait_queues #(
   parameter int unsigned NUM_SEMS   = 16,
   parameter int unsigned WAIT_DEPTH = 8,
   parameter int unsigned ID_BITS    = 16
) (
   input logic clock,
   input logic reset,
   stwq_req_if.sink   req,
   stwq_rsp_if.source rsp
);

   localparam int unsigned SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int unsigned SC = $clog2(NUM_SEMS + 1);
   localparam int unsigned QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int unsigned FW = $clog2(WAIT_DEPTH + 1);
   localparam int unsigned WA = $clog2(NUM_SEMS * WAIT_DEPTH) > 0 ?
                                $clog2(NUM_SEMS * WAIT_DEPTH) : 1;
   localparam int unsigned VB = stwq_pkg::ValueBits;

   typedef struct packed {
      logic [VB-1:0] count;
      logic [QW-1:0] head;
      logic [FW-1:0] fill;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_OUT  = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

   entry_type table_mem [NUM_SEMS];
   logic [ID_BITS-1:0] wait_mem [NUM_SEMS*WAIT_DEPTH];

   state_type state_ff, state_in;
   stwq_pkg::req_type req_ff;
   stwq_pkg::rsp_type rsp_ff, rsp_in;
   logic [NUM_SEMS-1:0] busy_ff, busy_in;
   logic [SC-1:0] fresh_ff, fresh_in;
   logic [SW-1:0] free_ff, free_in;
   logic free_vld_ff, free_vld_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic usable_ff, usable_in;
   logic grant_ff, grant_in;
   entry_type ent_rd_ff;
   logic [ID_BITS-1:0] wait_rd_ff;

   entry_type ent_wr;
   logic ent_we;
   logic [SW-1:0] ent_addr;
   logic wait_we;
   logic [WA-1:0] wait_waddr, wait_raddr;
   logic [QW-1:0] tail;
   logic [QW:0] tail_sum;
   logic [QW:0] head_inc;
   logic [31:0] idx_ext;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = rsp_ff;

   assign idx_ext = 32'(req_ff.slot_index);
   assign tail_sum = {1'b0, ent_rd_ff.head} + (QW+1)'(ent_rd_ff.fill);
   assign tail = (tail_sum >= (QW+1)'(WAIT_DEPTH)) ?
                 QW'(tail_sum - (QW+1)'(WAIT_DEPTH)) : QW'(tail_sum);
   assign head_inc = {1'b0, ent_rd_ff.head} + (QW+1)'(1);
   assign wait_raddr = WA'(slot_ff) * WA'(WAIT_DEPTH) + WA'(ent_rd_ff.head);
   assign wait_waddr = WA'(slot_ff) * WA'(WAIT_DEPTH) + WA'(tail);

   // table read port registered at S_READ
   always_ff @(posedge clock) begin
      ent_rd_ff  <= table_mem[slot_in];
      wait_rd_ff <= wait_mem[wait_raddr];
      if (ent_we) begin
         table_mem[ent_addr] <= ent_wr;
      end
      if (wait_we) begin
         wait_mem[wait_waddr] <= ID_BITS'(req_ff.caller);
      end
   end

   always_comb begin
      state_in    = state_ff;
      rsp_in      = rsp_ff;
      busy_in     = busy_ff;
      fresh_in    = fresh_ff;
      free_in     = free_ff;
      free_vld_in = free_vld_ff;
      scan_in     = scan_ff;
      slot_in     = slot_ff;
      usable_in   = usable_ff;
      grant_in    = grant_ff;
      ent_we      = 1'b0;
      ent_addr    = slot_ff;
      ent_wr      = ent_rd_ff;
      wait_we     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_READ;
               slot_in  = SW'(req.payload.slot_index);
            end
         end
         S_READ: begin
            rsp_in = '0;
            if (req_ff.cmd == stwq_pkg::CMD_INIT) begin
               usable_in = 1'b0;
               if (fresh_ff < SC'(NUM_SEMS)) begin
                  slot_in  = SW'(fresh_ff);
                  grant_in = 1'b1;
                  fresh_in = fresh_ff + SC'(1);
               end else if (free_vld_ff) begin
                  slot_in  = free_ff;
                  grant_in = 1'b1;
               end else begin
                  grant_in = 1'b0;
               end
            end else begin
               grant_in  = 1'b0;
               slot_in   = SW'(req_ff.slot_index);
               usable_in = (req_ff.slot_index != '0) && (idx_ext < NUM_SEMS) &&
                           busy_ff[SW'(req_ff.slot_index)];
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_OUT;
            priority if (req_ff.cmd == stwq_pkg::CMD_INIT) begin
               if (grant_ff) begin
                  busy_in[slot_ff] = 1'b1;
                  ent_we       = 1'b1;
                  ent_wr.count = req_ff.init_value;
                  ent_wr.head  = '0;
                  ent_wr.fill  = '0;
                  rsp_in.slot  = stwq_pkg::SlotBits'(slot_ff);
                  if (free_vld_ff && slot_ff == free_ff) begin
                     free_vld_in = 1'b0;
                     scan_in     = slot_ff;
                     state_in    = S_SCAN;
                  end
               end else begin
                  rsp_in.status = stwq_pkg::ST_NO_SPACE;
               end
            end else if (!usable_ff) begin
               rsp_in.status = stwq_pkg::ST_INVALID;
            end else if (req_ff.cmd == stwq_pkg::CMD_UP) begin
               ent_we = 1'b1;
               if (ent_rd_ff.fill == '0) begin
                  if (ent_rd_ff.count != stwq_pkg::CountMax) begin
                     ent_wr.count = ent_rd_ff.count + VB'(1);
                  end
               end else begin
                  rsp_in.wake_valid    = 1'b1;
                  rsp_in.wake_endpoint = stwq_pkg::WakeBits'(wait_rd_ff);
                  ent_wr.head = (head_inc >= (QW+1)'(WAIT_DEPTH)) ? '0 : QW'(head_inc);
                  ent_wr.fill = ent_rd_ff.fill - FW'(1);
               end
            end else if (req_ff.cmd == stwq_pkg::CMD_DOWN) begin
               if (ent_rd_ff.count != '0) begin
                  ent_we       = 1'b1;
                  ent_wr.count = ent_rd_ff.count - VB'(1);
               end else if (ent_rd_ff.fill >= FW'(WAIT_DEPTH)) begin
                  rsp_in.status = stwq_pkg::ST_NO_SPACE;
               end else begin
                  ent_we        = 1'b1;
                  wait_we       = 1'b1;
                  ent_wr.fill   = ent_rd_ff.fill + FW'(1);
                  rsp_in.status = stwq_pkg::ST_SUSPENDED;
               end
            end else begin
               if (ent_rd_ff.fill != '0) begin
                  rsp_in.status = stwq_pkg::ST_WAITERS;
               end else begin
                  busy_in[slot_ff] = 1'b0;
                  if (!free_vld_ff || free_ff > slot_ff) begin
                     free_in     = slot_ff;
                     free_vld_in = 1'b1;
                  end
               end
            end
         end
         S_SCAN: begin
            // search for the next released slot above the one just reused
            if ((SC'(scan_ff) + SC'(1) >= SC'(NUM_SEMS)) ||
                (SC'(scan_ff) + SC'(1) >= fresh_ff)) begin
               state_in = S_OUT;
            end else begin
               scan_in = scan_ff + SW'(1);
               if (!busy_ff[scan_ff + SW'(1)]) begin
                  free_in     = scan_ff + SW'(1);
                  free_vld_in = 1'b1;
                  state_in    = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         busy_ff     <= '0;
         fresh_ff    <= SC'(1);
         free_ff     <= '0;
         free_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         busy_ff     <= busy_in;
         fresh_ff    <= fresh_in;
         free_ff     <= free_in;
         free_vld_ff <= free_vld_in;
      end
      if (req.valid && req.ready) begin
         req_ff <= req.payload;
      end
      rsp_ff    <= rsp_in;
      scan_ff   <= scan_in;
      slot_ff   <= slot_in;
      usable_ff <= usable_in;
      grant_ff  <= grant_in;
   end

endmodule

/* rtl/core/stwq_checker.sv */
module stwq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input stwq_pkg::rsp_type rsp_payload
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result too early");

   a_wake_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.wake_valid) |-> rsp_payload.status == stwq_pkg::ST_OK)
      else $error("wake with bad status");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");

endmodule

bind semaphore_table_with_wait_queues stwq_checker u_stwq_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);
